### hw/rtl/hlst_pkg.sv
// Package: types, action codes and constants for the hop latency statistics table.
package hlst_pkg;

    localparam int HOP_COUNT_DEF = 32;
    localparam int ADDR_W        = 64;
    localparam int TIME_W        = 16;
    localparam int SUM_W         = 32;
    localparam int CNT_W         = 16;
    localparam int LOSS_W        = 7;
    localparam int RLEN_W        = 6;
    localparam int ACT_W         = 3;
    localparam int HOP_W         = 5;

    typedef enum logic [ACT_W-1:0] {
        ACT_CLEAR = 3'd0,
        ACT_PROBE = 3'd1,
        ACT_REPLY = 3'd2,
        ACT_RTT   = 3'd3,
        ACT_ADDR  = 3'd4,
        ACT_READ  = 3'd5,
        ACT_ROUTE = 3'd6,
        ACT_NONE  = 3'd7
    } action_t;

    typedef enum logic {
        CFG_TARGET_HIGH = 1'b0,
        CFG_TARGET_LOW  = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [ADDR_W-1:0] addr_high;
        logic [ADDR_W-1:0] addr_low;
        logic [TIME_W-1:0] last;
        logic [SUM_W-1:0]  sum;
        logic [TIME_W-1:0] best;
        logic [TIME_W-1:0] worst;
        logic [CNT_W-1:0]  replies;
        logic [CNT_W-1:0]  probes;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

### hw/rtl/hop_latency_statistics_table.sv
// Top level: per-hop statistics table with shared iterative divider.
//
//  channel  | handshake                      | payload
//  ---------+--------------------------------+------------------------------------------
//  in       | in_valid / in_ready            | action, hop, rtt, address_high/low
//  out      | out_valid / out_ready          | hop snapshot, average, loss, flags
//  cfg      | cfg_write                      | cfg_index, cfg_data
//
// One item at a time. A plain action runs these steps from one accept to the next:
// accept, read, update, two 32-step divisions on the shared divider, result (held
// until out_ready). A route action first scans up to HOP_COUNT hops (read, compare).
// Reset and clear-all zero the table at once via per-entry valid bits.
// in_ready is low while an item is in work or its result waits.
module hop_latency_statistics_table
    import hlst_pkg::*;
#(
    parameter int HOP_COUNT = HOP_COUNT_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  logic              cfg_index,
    input  logic [ADDR_W-1:0] cfg_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [ACT_W-1:0]  action,
    input  logic [HOP_W-1:0]  hop,
    input  logic [TIME_W-1:0] rtt,
    input  logic [ADDR_W-1:0] address_high,
    input  logic [ADDR_W-1:0] address_low,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [ADDR_W-1:0] hop_address_high,
    output logic [ADDR_W-1:0] hop_address_low,
    output logic [TIME_W-1:0] last_time,
    output logic [TIME_W-1:0] best_time,
    output logic [TIME_W-1:0] worst_time,
    output logic [TIME_W-1:0] average_time,
    output logic [LOSS_W-1:0] loss_percent,
    output logic [CNT_W-1:0]  replies_seen,
    output logic [CNT_W-1:0]  probes_sent,
    output logic              address_was_new,
    output logic [RLEN_W-1:0] route_length
);

    localparam int IDX_W = (HOP_COUNT > 1) ? $clog2(HOP_COUNT) : 1;
    localparam int LEN_W = $clog2(HOP_COUNT + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HOP_COUNT - 1);

    typedef enum logic [7:0] {
        ST_IDLE     = 8'b00000001,
        ST_SCAN_RD  = 8'b00000010,
        ST_SCAN_CMP = 8'b00000100,
        ST_RD       = 8'b00001000,
        ST_MOD      = 8'b00010000,
        ST_DIV_AVG  = 8'b00100000,
        ST_DIV_LOSS = 8'b01000000,
        ST_DONE     = 8'b10000000
    } state_t;

    state_t             state_reg, state_next;

    logic [ADDR_W-1:0]  tgt_high_reg, tgt_low_reg;
    action_t            act_reg;
    logic [HOP_W-1:0]   hop_reg;
    logic [TIME_W-1:0]  rtt_reg;
    logic [ADDR_W-1:0]  ah_reg, al_reg;

    logic [ENTRY_W-1:0] mem [HOP_COUNT];
    logic [HOP_COUNT-1:0] valid_reg;
    logic [ENTRY_W-1:0] rd_data_reg;
    logic               rd_valid_reg;
    logic [IDX_W-1:0]   rd_addr;
    logic               rd_en;
    logic               wr_en;
    entry_t             wr_entry;

    logic [IDX_W-1:0]   idx_reg;
    logic [IDX_W-1:0]   run_start_reg;
    logic [ADDR_W-1:0]  prev_high_reg, prev_low_reg;
    logic [LEN_W-1:0]   rlen_reg;

    entry_t             snap_reg;
    logic               new_reg;

    logic [SUM_W-1:0]   q_reg;
    logic [CNT_W-1:0]   rem_reg;
    logic [CNT_W-1:0]   dvs_reg;
    logic [4:0]         cnt_reg;
    logic [TIME_W-1:0]  avg_reg;

    logic [CNT_W:0]     rem_sh;
    logic               ge;
    logic [CNT_W-1:0]   rem_n;
    logic [SUM_W-1:0]   q_n;

    entry_t             cur;
    entry_t             upd;
    logic               ok;
    logic               upd_new;
    logic [SUM_W:0]     sum_ext;
    logic               addr_match;
    logic               run_cont;
    logic [SUM_W-1:0]   ratio_dvd;
    logic [TIME_W-1:0]  avg_n;
    logic [LOSS_W-1:0]  loss_n;

    assign ok       = int'(hop_reg) < HOP_COUNT;
    assign cur      = rd_valid_reg ? entry_t'(rd_data_reg) : '0;
    assign in_ready = (state_reg == ST_IDLE);

    // divider step
    assign rem_sh = {rem_reg, q_reg[SUM_W-1]};
    assign ge     = rem_sh >= {1'b0, dvs_reg};
    assign rem_n  = ge ? CNT_W'(rem_sh - {1'b0, dvs_reg}) : rem_sh[CNT_W-1:0];
    assign q_n    = {q_reg[SUM_W-2:0], ge};

    assign ratio_dvd = SUM_W'({7'd0, snap_reg.replies} + ({7'd0, snap_reg.replies} << 5)
                       + ({7'd0, snap_reg.replies} << 6) - ({7'd0, snap_reg.replies} << 0)
                       + ({7'd0, snap_reg.replies} << 2) - ({7'd0, snap_reg.replies} << 0)
                       + ({7'd0, snap_reg.replies} << 0));

    assign addr_match = (cur.addr_high == tgt_high_reg) && (cur.addr_low == tgt_low_reg);
    assign run_cont   = (idx_reg != '0) && (cur.addr_high == prev_high_reg)
                        && (cur.addr_low == prev_low_reg)
                        && ((cur.addr_high != '0) || (cur.addr_low != '0));

    always_comb
    begin
        avg_n = (snap_reg.replies == '0) ? '0 :
                (q_n[SUM_W-1:TIME_W] != '0) ? '1 : q_n[TIME_W-1:0];
        if (snap_reg.probes == '0)
        begin
            loss_n = '0;
        end
        else if (q_n >= SUM_W'(100))
        begin
            loss_n = '0;
        end
        else
        begin
            loss_n = LOSS_W'(7'd100 - q_n[LOSS_W-1:0]);
        end
    end

    always_comb
    begin
        upd     = cur;
        upd_new = 1'b0;
        wr_en   = 1'b0;
        sum_ext = {1'b0, cur.sum} + {{(SUM_W-TIME_W+1){1'b0}}, rtt_reg};
        case (act_reg)
            ACT_PROBE:
            begin
                if (cur.probes != '1)
                begin
                    upd.probes = cur.probes + 1'b1;
                end
                wr_en = 1'b1;
            end
            ACT_REPLY:
            begin
                if (cur.replies != '1)
                begin
                    upd.replies = cur.replies + 1'b1;
                end
                wr_en = 1'b1;
            end
            ACT_RTT:
            begin
                upd.last = rtt_reg;
                upd.sum  = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
                if ((cur.best > rtt_reg) || (cur.probes == CNT_W'(1)))
                begin
                    upd.best = rtt_reg;
                end
                if (cur.worst < rtt_reg)
                begin
                    upd.worst = rtt_reg;
                end
                wr_en = 1'b1;
            end
            ACT_ADDR:
            begin
                if ((cur.addr_high == '0) && (cur.addr_low == '0)
                    && ((ah_reg != '0) || (al_reg != '0)))
                begin
                    upd.addr_high = ah_reg;
                    upd.addr_low  = al_reg;
                    upd_new       = 1'b1;
                    wr_en         = 1'b1;
                end
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
        wr_en    = wr_en && ok && (state_reg == ST_MOD);
        wr_entry = upd;
    end

    always_comb
    begin
        rd_addr = IDX_W'(hop_reg);
        rd_en   = 1'b0;
        if (state_reg == ST_SCAN_RD)
        begin
            rd_addr = idx_reg;
            rd_en   = 1'b1;
        end
        else if (state_reg == ST_RD)
        begin
            rd_en = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[IDX_W'(hop_reg)] <= wr_entry;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready && (action_t'(action) == ACT_CLEAR))
            begin
                valid_reg <= '0;
            end
            else if (wr_en)
            begin
                valid_reg[IDX_W'(hop_reg)] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (action_t'(action) == ACT_ROUTE) ? ST_SCAN_RD : ST_RD;
                end
            end
            ST_SCAN_RD:
            begin
                state_next = ST_SCAN_CMP;
            end
            ST_SCAN_CMP:
            begin
                state_next = (addr_match || (idx_reg == LAST_IDX)) ? ST_RD : ST_SCAN_RD;
            end
            ST_RD:
            begin
                state_next = ST_MOD;
            end
            ST_MOD:
            begin
                state_next = ST_DIV_AVG;
            end
            ST_DIV_AVG:
            begin
                if (cnt_reg == '1)
                begin
                    state_next = ST_DIV_LOSS;
                end
            end
            ST_DIV_LOSS:
            begin
                if (cnt_reg == '1)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            tgt_high_reg <= '0;
            tgt_low_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write)
            begin
                case (cfg_reg_t'(cfg_index))
                    CFG_TARGET_HIGH: tgt_high_reg <= cfg_data;
                    CFG_TARGET_LOW:  tgt_low_reg  <= cfg_data;
                    default:         tgt_low_reg  <= tgt_low_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                act_reg       <= action_t'(action);
                hop_reg       <= hop;
                rtt_reg       <= rtt;
                ah_reg        <= address_high;
                al_reg        <= address_low;
                idx_reg       <= '0;
                run_start_reg <= '0;
                rlen_reg      <= '0;
            end
            ST_SCAN_CMP:
            begin
                prev_high_reg <= cur.addr_high;
                prev_low_reg  <= cur.addr_low;
                if (!run_cont)
                begin
                    run_start_reg <= idx_reg;
                end
                if (addr_match)
                begin
                    rlen_reg <= LEN_W'(idx_reg) + 1'b1;
                end
                else if (idx_reg == LAST_IDX)
                begin
                    rlen_reg <= run_cont ? LEN_W'(run_start_reg) + 1'b1
                                         : LEN_W'(idx_reg) + 1'b1;
                end
                idx_reg <= idx_reg + 1'b1;
            end
            ST_MOD:
            begin
                snap_reg <= ok ? upd : '0;
                new_reg  <= upd_new && ok && (act_reg == ACT_ADDR);
                q_reg    <= ok ? upd.sum : '0;
                dvs_reg  <= upd.replies;
                rem_reg  <= '0;
                cnt_reg  <= '0;
            end
            ST_DIV_AVG:
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == '1)
                begin
                    avg_reg <= avg_n;
                    q_reg   <= ratio_dvd;
                    dvs_reg <= snap_reg.probes;
                    rem_reg <= '0;
                end
                else
                begin
                    q_reg   <= q_n;
                    rem_reg <= rem_n;
                end
            end
            ST_DIV_LOSS:
            begin
                cnt_reg <= cnt_reg + 1'b1;
                q_reg   <= q_n;
                rem_reg <= rem_n;
                if (cnt_reg == '1)
                begin
                    hop_address_high <= snap_reg.addr_high;
                    hop_address_low  <= snap_reg.addr_low;
                    last_time        <= snap_reg.last;
                    best_time        <= snap_reg.best;
                    worst_time       <= snap_reg.worst;
                    average_time     <= avg_reg;
                    loss_percent     <= loss_n;
                    replies_seen     <= snap_reg.replies;
                    probes_sent      <= snap_reg.probes;
                    address_was_new  <= new_reg;
                    route_length     <= RLEN_W'(rlen_reg);
                end
            end
            default:
            begin
                cnt_reg <= cnt_reg;
            end
        endcase
    end

    assign out_valid = (state_reg == ST_DONE);

endmodule
